[rtl/tkst_pkg.sv]
// ----------------------------------------------------------------------------
// tkst_pkg
// Shared types and codes for the sorted top-k insertion table.
// ----------------------------------------------------------------------------
package tkst_pkg;

   localparam logic [1:0] MODE_ADD   = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;
   localparam logic [1:0] MODE_NOP   = 2'd3;

   localparam logic [2:0] STATUS_ADDED    = 3'd0;
   localparam logic [2:0] STATUS_DROPPED  = 3'd1;
   localparam logic [2:0] STATUS_READ_OK  = 3'd2;
   localparam logic [2:0] STATUS_READ_OOR = 3'd3;
   localparam logic [2:0] STATUS_CLEARED  = 3'd4;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] entry_time;
      logic [15:0] fail_count;
      logic [31:0] now_stamp;
      logic [3:0]  read_index;
   } tkst_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [4:0]  entry_count;
      logic [3:0]  insert_rank;
      logic [31:0] out_time;
      logic [15:0] out_fails;
      logic [31:0] out_stamp;
   } tkst_rsp_type;

   // one table entry as held in a cell
   typedef struct packed {
      logic [31:0] key;
      logic [15:0] side;
      logic [31:0] stamp;
   } tkst_entry_type;

   // insert command broadcast to every cell
   typedef struct packed {
      logic           add_en;
      tkst_entry_type entry;
   } tkst_ins_type;

endpackage

[rtl/top_k_sorted_insert_table_top.sv]
// ----------------------------------------------------------------------------
// top_k_sorted_insert_table_top
// Keeps up to DEPTH entries sorted by key in a chain of rank cells.
// Response is registered: valid in the cycle after the request is accepted.
// Throughput: 1 request per cycle unless a stalled response blocks; every
//   cell compares in parallel and shifts in the same cycle; no add iterates.
// Reset: synchronous; clears the entry count and the response valid only.
// ----------------------------------------------------------------------------
module top_k_sorted_insert_table_top #(
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tkst_pkg::tkst_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tkst_pkg::tkst_rsp_type rsp_data
);
   import tkst_pkg::*;

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int RANK_W = $clog2(DEPTH);
   localparam int CMP_W  = CNT_W + 4;

   // handshake and output register
   logic         accept;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   tkst_rsp_type rsp_data_ff;
   tkst_rsp_type rsp_data_in;

   // entry count
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             full;

   // cell chain
   tkst_ins_type   ins;
   tkst_entry_type cell_entry [DEPTH];
   logic           cell_shift [DEPTH];
   logic           cell_occ   [DEPTH];

   // result helpers
   logic [RANK_W-1:0]   rank_sel;
   logic [RANK_W+3:0]   rank_wide;
   logic [CNT_W+4:0]    cnt_wide;
   logic [CMP_W-1:0]    idx_ext;
   logic [CMP_W-1:0]    cnt_ext;
   tkst_entry_type      rd_entry;
   logic                rd_ok;

   // Output register frees up whenever it is empty or being taken.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign full = (count_ff == CNT_W'(DEPTH));

   assign ins.add_en       = accept && (req_data.mode == MODE_ADD);
   assign ins.entry.key    = req_data.entry_time;
   assign ins.entry.side   = req_data.fail_count;
   assign ins.entry.stamp  = req_data.now_stamp;

   // Rank cells: cell i is occupied when i is below the count. Cell 0 has
   // no left neighbor, so it always takes the new entry when it shifts.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign cell_occ[i] = (CNT_W'(i) < count_ff);
      if (i == 0) begin : g_head
         tkst_cell u_cell (
            .clock      (clock),
            .ins        (ins),
            .occupied   (cell_occ[i]),
            .left_entry (ins.entry),
            .left_shift (1'b0),
            .entry      (cell_entry[i]),
            .shift      (cell_shift[i])
         );
      end else begin : g_body
         tkst_cell u_cell (
            .clock      (clock),
            .ins        (ins),
            .occupied   (cell_occ[i]),
            .left_entry (cell_entry[i-1]),
            .left_shift (cell_shift[i-1]),
            .entry      (cell_entry[i]),
            .shift      (cell_shift[i])
         );
      end
   end

   // Insert rank: the first cell that shifts. The boundary is one-hot, so an
   // OR of indices encodes it. When full and nothing shifts, this is zero.
   always_comb begin
      rank_sel = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (cell_shift[i] && ((i == 0) || !cell_shift[(i == 0) ? 0 : i - 1])) begin
            rank_sel = rank_sel | RANK_W'(i);
         end
      end
   end

   // Read port: one-hot select on the requested rank.
   assign idx_ext = CMP_W'(req_data.read_index);
   assign cnt_ext = CMP_W'(count_ff);
   assign rd_ok   = (idx_ext < cnt_ext);

   always_comb begin
      rd_entry = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (idx_ext == CMP_W'(i)) begin
            rd_entry = rd_entry | cell_entry[i];
         end
      end
   end

   // Count update
   always_comb begin
      count_in = count_ff;
      if (accept) begin
         unique case (req_data.mode)
            MODE_ADD: begin
               if (!full) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            MODE_CLEAR: count_in = '0;
            MODE_READ,
            MODE_NOP:   count_in = count_ff;
         endcase
      end
   end

   assign rank_wide = {4'b0, rank_sel};
   assign cnt_wide  = {5'b0, count_in};

   // Response build
   always_comb begin
      rsp_data_in             = '0;
      rsp_data_in.entry_count = cnt_wide[4:0];
      unique case (req_data.mode)
         MODE_ADD: begin
            // full and no cell shifts: new key is no better than the worst
            if (full && !cell_shift[DEPTH-1]) begin
               rsp_data_in.status = STATUS_DROPPED;
            end else begin
               rsp_data_in.status      = STATUS_ADDED;
               rsp_data_in.insert_rank = rank_wide[3:0];
            end
         end
         MODE_READ: begin
            if (rd_ok) begin
               rsp_data_in.status    = STATUS_READ_OK;
               rsp_data_in.out_time  = rd_entry.key;
               rsp_data_in.out_fails = rd_entry.side;
               rsp_data_in.out_stamp = rd_entry.stamp;
            end else begin
               rsp_data_in.status = STATUS_READ_OOR;
            end
         end
         MODE_CLEAR: rsp_data_in.status = STATUS_CLEARED;
         MODE_NOP:   rsp_data_in.status = STATUS_DROPPED;
      endcase
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

[rtl/tkst_cell.sv]
// ----------------------------------------------------------------------------
// tkst_cell
// One rank of the sorted table: keeps, shifts in its left neighbor, or
// takes the new entry.
// ----------------------------------------------------------------------------
module tkst_cell (
   input  logic                    clock,
   input  tkst_pkg::tkst_ins_type   ins,
   input  logic                    occupied,
   input  tkst_pkg::tkst_entry_type left_entry,
   input  logic                    left_shift,
   output tkst_pkg::tkst_entry_type entry,
   output logic                    shift
);
   import tkst_pkg::*;

   tkst_entry_type entry_ff;
   tkst_entry_type entry_in;

   // new key goes at or before this rank; equal keys stay ahead
   assign shift = !occupied || (entry_ff.key > ins.entry.key);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ins.add_en && shift) begin
         entry_in = left_shift ? left_entry : ins.entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

[rtl/tkst_checker.sv]
// ----------------------------------------------------------------------------
// tkst_checker
// Port-level checks for the sorted top-k insertion table.
// ----------------------------------------------------------------------------
module tkst_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input tkst_pkg::tkst_req_type req_data,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input tkst_pkg::tkst_rsp_type rsp_data
);
   import tkst_pkg::*;

   // every accepted request shows a response next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted request produced no response");

   // a clear empties the table
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_data.mode == MODE_CLEAR)) |=>
      ((rsp_data.status == STATUS_CLEARED) && (rsp_data.entry_count == 5'd0)))
      else $error("clear response wrong");

   // data fields are zero unless a read hit
   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != STATUS_READ_OK)) |->
      ((rsp_data.out_time == 32'd0) && (rsp_data.out_fails == 16'd0) &&
       (rsp_data.out_stamp == 32'd0)))
      else $error("nonzero data on non-read response");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

endmodule

bind top_k_sorted_insert_table_top tkst_checker u_tkst_checker (.*);
